@@ rtl/core/rsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rsl_pkg
// Shared types and constants of the per-source rate limiter: request and
// result beats, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rsl_pkg;

  localparam int ADDR_W = 32;
  localparam int TIME_W = 32;
  localparam int SLOT_W = 6;

  // register byte offsets
  localparam logic [1:0] REG_IDLE_EXPIRY = 2'd0;
  localparam logic [TIME_W-1:0] IDLE_EXPIRY_RST = 32'd60000;

  typedef struct packed {
    logic [ADDR_W-1:0] source_address;
    logic [TIME_W-1:0] now_ms;
    logic [TIME_W-1:0] min_interval_ms;
  } req_t;

  typedef struct packed {
    logic              limited;
    logic [SLOT_W-1:0] slot_used;
  } res_t;

  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_idx;
    logic              proc;
    logic [SLOT_W-1:0] proc_idx;
    logic              finish;
  } dp_cmd_t;

  typedef struct packed {
    logic match;
  } dp_sts_t;

endpackage

@@ rtl/core/per_source_rate_limiter.sv @@
// ----------------------------------------------------------------------------
// per_source_rate_limiter
// Minimum-interval rate limiting per source address over a small table,
// with idle expiry of entries and oldest-entry replacement.
//
//   channel   ports                              beat marked by
//   -------   --------------------------------   --------------------------
//   request   start, busy, in_req                start & !busy
//   result    out_valid, out_res                 out_valid, one cycle
//   config    psel penable pwrite paddr pwdata   psel & penable & pwrite
//             prdata pready
//
// after accept the table is read one entry per cycle through a registered
// read port, each read is retired in the cycle after it, and a done state
// does the interval check and table update ahead of the registered result
// strobe; a scan ends early at the first address hit
// busy drops in the one-cycle result strobe; no request is taken during a scan
// synchronous active-low reset empties the table and loads the expiry default
// ----------------------------------------------------------------------------
module per_source_rate_limiter
  import rsl_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  req_t        in_req,
  output logic        out_valid,
  output res_t        out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [TIME_W-1:0] idle_expiry_r;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_expiry_r <= IDLE_EXPIRY_RST;
    end else if (psel && penable && pwrite && paddr == REG_IDLE_EXPIRY) begin
      idle_expiry_r <= pwdata;
    end
  end

  assign prdata = (paddr == REG_IDLE_EXPIRY) ? idle_expiry_r : '0;
  assign pready = 1'b1;

  rsl_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  rsl_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req      (in_req),
    .idle_expiry (idle_expiry_r),
    .out_valid   (out_valid),
    .out_res     (out_res)
  );

endmodule

@@ rtl/core/rsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsl_ctrl
// Scan sequencer: issues one table read per cycle, retires the read from the
// previous cycle, and stops at the first address hit or after the last slot.
// ----------------------------------------------------------------------------
module rsl_ctrl
  import rsl_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t          state_r, state_nxt;
  logic [IW-1:0]   rd_idx_r, rd_idx_nxt;
  logic            rd_more_r, rd_more_nxt;
  logic            proc_v_r, proc_v_nxt;
  logic [IW-1:0]   proc_idx_r, proc_idx_nxt;

  always_comb begin
    state_nxt    = state_r;
    rd_idx_nxt   = rd_idx_r;
    rd_more_nxt  = rd_more_r;
    proc_v_nxt   = proc_v_r;
    proc_idx_nxt = proc_idx_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          state_nxt   = ST_SCAN;
          rd_idx_nxt  = '0;
          rd_more_nxt = 1'b1;
          proc_v_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_more_r) begin
          cmd.rd_en    = 1'b1;
          proc_v_nxt   = 1'b1;
          proc_idx_nxt = rd_idx_r;
          rd_more_nxt  = (rd_idx_r != LAST);
          if (rd_idx_r != LAST) begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
        end else begin
          proc_v_nxt = 1'b0;
        end
        // read data of the previous cycle is retired here
        if (proc_v_r) begin
          cmd.proc = 1'b1;
          if (sts.match || proc_idx_r == LAST) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.rd_idx   = SLOT_W'(rd_idx_r);
    cmd.proc_idx = SLOT_W'(proc_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      rd_idx_r   <= '0;
      rd_more_r  <= 1'b0;
      proc_v_r   <= 1'b0;
      proc_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_idx_r   <= rd_idx_nxt;
      rd_more_r  <= rd_more_nxt;
      proc_v_r   <= proc_v_nxt;
      proc_idx_r <= proc_idx_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

@@ rtl/core/rsl_dpath.sv @@
// ----------------------------------------------------------------------------
// rsl_dpath
// Source/time table with per-entry valid bits, expiry and match compare,
// empty and oldest slot tracking, and the final interval check and update.
// ----------------------------------------------------------------------------
module rsl_dpath
  import rsl_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  req_t              in_req,
  input  logic [TIME_W-1:0] idle_expiry,
  output logic              out_valid,
  output res_t              out_res
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [ADDR_W-1:0] src_mem [SLOTS];
  logic [TIME_W-1:0] tim_mem [SLOTS];
  logic [SLOTS-1:0]  vld_r, vld_nxt;

  req_t              req_r;
  logic [ADDR_W-1:0] rd_src_r;
  logic [TIME_W-1:0] rd_tim_r;
  logic              rd_vld_r;

  logic              found_r;
  logic [IW-1:0]     pick_r;
  logic [TIME_W-1:0] pick_tim_r;
  logic              empty_seen_r;
  logic [IW-1:0]     empty_idx_r;
  logic [IW-1:0]     oldest_idx_r;
  logic [TIME_W-1:0] oldest_tim_r;

  logic              out_valid_r;
  res_t              out_res_r;

  logic [ADDR_W-1:0] src_e, src_x;
  logic [TIME_W-1:0] tim_e, tim_x;
  logic              expire;
  logic              match;
  logic [IW-1:0]     proc_idx;
  logic [IW-1:0]     fin_idx;
  logic [TIME_W-1:0] fin_tim;
  logic [TIME_W-1:0] fin_gap;
  logic              refused;
  logic              wr_en;

  assign proc_idx = cmd.proc_idx[IW-1:0];

  // entries not yet written since reset read as empty
  assign src_e  = rd_vld_r ? rd_src_r : '0;
  assign tim_e  = rd_vld_r ? rd_tim_r : '0;
  assign expire = (src_e != '0) && ((req_r.now_ms - tim_e) > idle_expiry);
  assign src_x  = expire ? '0 : src_e;
  assign tim_x  = expire ? '0 : tim_e;
  assign match  = (src_x == req_r.source_address);

  assign sts.match = match;

  always_comb begin
    priority if (found_r) begin
      fin_idx = pick_r;
      fin_tim = pick_tim_r;
    end else if (empty_seen_r) begin
      fin_idx = empty_idx_r;
      fin_tim = '0;
    end else begin
      fin_idx = oldest_idx_r;
      fin_tim = '0;
    end
    fin_gap = req_r.now_ms - fin_tim;
    refused = (fin_gap < req_r.min_interval_ms);
    // a hit that is refused leaves its entry alone
    wr_en   = cmd.finish && (!found_r || !refused);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (cmd.proc && expire) begin
      vld_nxt[proc_idx] = 1'b0;
    end
    if (wr_en) begin
      vld_nxt[fin_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_src_r <= src_mem[cmd.rd_idx[IW-1:0]];
      rd_tim_r <= tim_mem[cmd.rd_idx[IW-1:0]];
      rd_vld_r <= vld_r[cmd.rd_idx[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      src_mem[fin_idx] <= req_r.source_address;
      tim_mem[fin_idx] <= refused ? '0 : req_r.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.proc) begin
      if (match) begin
        pick_r     <= proc_idx;
        pick_tim_r <= tim_x;
      end else begin
        if (proc_idx == '0 || tim_x < oldest_tim_r) begin
          oldest_idx_r <= proc_idx;
          oldest_tim_r <= tim_x;
        end
        if (!empty_seen_r && src_x == '0) begin
          empty_idx_r <= proc_idx;
        end
      end
    end
    if (cmd.finish) begin
      out_res_r.limited   <= refused;
      out_res_r.slot_used <= SLOT_W'(fin_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      found_r      <= 1'b0;
      empty_seen_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      vld_r       <= vld_nxt;
      out_valid_r <= cmd.finish;
      if (cmd.load) begin
        found_r      <= 1'b0;
        empty_seen_r <= 1'b0;
      end else if (cmd.proc) begin
        if (match) begin
          found_r <= 1'b1;
        end else if (src_x == '0) begin
          empty_seen_r <= 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
